// ===== hw/rtl/gpf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// GPS / odometry pose fuser package
// Shared types, register indexes, CORDIC constants and sequencer states.
// ----------------------------------------------------------------------------
package gpf_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TICK_PERIOD    = 2'd0;
  localparam logic [1:0] REG_GPS_GAIN       = 2'd1;
  localparam logic [1:0] REG_HEADING_GAIN   = 2'd2;
  localparam logic [1:0] REG_MOVE_THRESHOLD = 2'd3;

  localparam int CFG_WIDTH = 31;

  // Register reset values
  localparam logic [15:0] TICK_PERIOD_RST    = 16'd655;
  localparam logic [15:0] GPS_GAIN_RST       = 16'd131;
  localparam logic [15:0] HEADING_GAIN_RST   = 16'd6554;
  localparam logic [30:0] MOVE_THRESHOLD_RST = 31'd6554;

  // CORDIC constants
  localparam int CORDIC_ITERS = 16;
  localparam int CORDIC_K     = 652032874;   // 1/gain in Q2.30
  localparam int RAD_TO_ANG   = 1367130551;  // round(2^32/pi)
  localparam int DL_WIDTH     = 21;          // per-tick travel, Q5.16

  localparam logic [15:0] ATAN_TAB [CORDIC_ITERS] = '{
    16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
    16'd41,   16'd20,   16'd10,   16'd5,    16'd3,   16'd1,   16'd1,   16'd0
  };

  typedef struct packed {
    logic               start_req;
    logic signed [31:0] gps_x;
    logic signed [31:0] gps_y;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] speed;
  } in_t;

  typedef struct packed {
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [15:0] est_yaw;
    logic               corrected;
  } out_t;

  typedef struct packed {
    logic go;
    logic vect;   // 1: atan2 (vectoring), 0: sin/cos (rotation)
  } cor_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cor_rsp_t;

  typedef enum logic [2:0] {
    COR_IDLE, COR_NORM, COR_FLIP, COR_ITER, COR_DONE
  } cor_state_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_BX, ST_BY, ST_DL, ST_RT, ST_RAD, ST_INC,
    ST_SC_GO, ST_SC_WT, ST_DX, ST_DY, ST_DYU, ST_CHK,
    ST_AG_GO, ST_AG_WT, ST_AO_GO, ST_AO_WT, ST_ERR, ST_CV, ST_OUT
  } seq_state_e;

endpackage
`default_nettype wire

// ===== hw/rtl/gps_odometry_pose_fuser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// GPS / odometry pose fuser
// Complementary filter: blends position toward GPS, integrates yaw rate,
// dead-reckons odometry and trims heading from GPS vs odometry bearings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one filter
//   tick per transfer. Output channel (out_valid_o / out_stall_i /
//   out_data_o) returns one pose per tick, in order.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i);
//   write it only while the block is idle.
// Sequencing:
//   One tick at a time: the input stalls until the pose has been handed
//   to the output register. A tick without heading correction runs a CORDIC
//   rotation (16 steps plus done) and the multiply/round sequence on the
//   single shared multiplier. A correction adds two atan2 passes, each
//   preceded by one-bit normalization shifts that bring the largest operand
//   magnitude into [2^38, 2^39) (a zero vector pass goes straight to done),
//   plus a multiply and a heading update to scale and apply the error.
// Reset:
//   Pose, anchor, accumulators and heading clear; registers take defaults.
// Stall:
//   The finished pose sits in an output register; the next tick is taken
//   while it waits. A tick finishing while the old pose is still stalled
//   holds until that transfer completes.
// ----------------------------------------------------------------------------
module gps_odometry_pose_fuser import gpf_pkg::*; #(
  parameter int ANGLE_BITS    = 16,
  parameter int POSITION_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire in_t                  in_data_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      out_t                 out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [CFG_WIDTH-1:0] cfg_wdata_i
);

  localparam int AB  = ANGLE_BITS;
  localparam int PB  = POSITION_BITS;
  localparam int UP  = (AB > 16) ? AB - 16 : 0;
  localparam int DN  = (AB < 16) ? 16 - AB : 0;
  localparam int MW  = ((PB > 32) ? PB : 32) + 1;   // multiplier operand A
  localparam int MB  = 33;                          // multiplier operand B
  localparam int PW  = MW + MB;                     // product
  localparam int SW  = MW + 1;                      // pre-saturation sums
  localparam int TW  = ((PB > 31) ? PB : 31) + 1;   // threshold compare
  localparam int DW  = (PB + 2 > 42) ? PB + 2 : 42; // CORDIC datapath
  localparam int CIN = PB + 1;

  localparam logic signed [SW-1:0] PMAX_S = SW'((SW'(1) << (PB - 1)) - SW'(1));
  localparam logic signed [SW-1:0] PMIN_S = -PMAX_S - SW'(1);
  localparam logic signed [SW-1:0] I32MAX = SW'(64'h7FFF_FFFF);
  localparam logic signed [SW-1:0] I32MIN = -I32MAX - SW'(1);

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                               input int s);
    logic [PW-1:0] m;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    m = (m + (PW'(1) << (s - 1))) >> s;
    return v[PW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [PB-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v;
    if (v > PMAX_S) r = PMAX_S;
    else if (v < PMIN_S) r = PMIN_S;
    return r[PB-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PB-1:0] v);
    logic signed [SW-1:0] w;
    w = SW'(v);
    if (w > I32MAX) w = I32MAX;
    else if (w < I32MIN) w = I32MIN;
    return w[31:0];
  endfunction

  // Configuration registers
  logic [15:0] tick_q, ggain_q, hgain_q;
  logic [30:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= TICK_PERIOD_RST;
      ggain_q <= GPS_GAIN_RST;
      hgain_q <= HEADING_GAIN_RST;
      thr_q   <= MOVE_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TICK_PERIOD:    tick_q  <= cfg_wdata_i[15:0];
        REG_GPS_GAIN:       ggain_q <= cfg_wdata_i[15:0];
        REG_HEADING_GAIN:   hgain_q <= cfg_wdata_i[15:0];
        REG_MOVE_THRESHOLD: thr_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Filter state
  seq_state_e state_q, state_d;
  in_t        in_q;
  logic [AB-1:0]        heading_q;
  logic signed [PB-1:0] px_q, py_q, ax_q, ay_q, sx_q, sy_q, trav_q;
  logic signed [DL_WIDTH-1:0] dl_q;
  logic signed [PW-1:0] prod_q, prod_d;
  logic [15:0] ag_q;
  logic        corr_q;
  out_t        out_q;
  logic        out_valid_q;

  // Shared multiplier and CORDIC controls
  logic signed [MW-1:0]  mul_a;
  logic signed [MB-1:0]  mul_b;
  cor_cmd_t              cor_cmd;
  cor_rsp_t              cor_rsp;
  logic signed [CIN-1:0] cor_x, cor_y;
  logic signed [DW-1:0]  cor_xo, cor_yo;
  logic [15:0]           cor_zo, h16;

  logic signed [PW-1:0] r12, r16, r30, rinc, rcv;
  logic [TW-1:0]        tmag;
  logic                 out_free;
  logic signed [15:0]   err;

  assign h16  = 16'({heading_q, 16'b0} >> AB);
  assign r12  = rnd(prod_q, 12);
  assign r16  = rnd(prod_q, 16);
  assign r30  = rnd(prod_q, 30);
  assign rinc = rnd(prod_q, 61 - AB);
  assign rcv  = rnd(prod_q <<< UP, 16 + DN);
  assign tmag = trav_q[PB-1] ? (TW'(0) - TW'(trav_q)) : TW'(trav_q);
  assign err  = $signed(ag_q - cor_zo);   // wraps: exactly pi reads as -pi
  assign out_free = !out_valid_q || !out_stall_i;
  assign prod_d = mul_a * mul_b;

  gpf_cordic #(.DW(DW), .CIN(CIN)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cor_cmd),
    .ang_i  (h16),
    .xin_i  (cor_x),
    .yin_i  (cor_y),
    .x_o    (cor_xo),
    .y_o    (cor_yo),
    .z_o    (cor_zo),
    .rsp_o  (cor_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_BX;
      ST_BX:    state_d = ST_BY;
      ST_BY:    state_d = ST_DL;
      ST_DL:    state_d = ST_RT;
      ST_RT:    state_d = ST_RAD;
      ST_RAD:   state_d = ST_INC;
      ST_INC:   state_d = ST_SC_GO;
      ST_SC_GO: state_d = ST_SC_WT;
      ST_SC_WT: if (cor_rsp.done) state_d = ST_DX;
      ST_DX:    state_d = ST_DY;
      ST_DY:    state_d = ST_DYU;
      ST_DYU:   state_d = ST_CHK;
      ST_CHK:   state_d = (tmag > TW'(thr_q)) ? ST_AG_GO : ST_OUT;
      ST_AG_GO: state_d = ST_AG_WT;
      ST_AG_WT: if (cor_rsp.done) state_d = ST_AO_GO;
      ST_AO_GO: state_d = ST_AO_WT;
      ST_AO_WT: if (cor_rsp.done) state_d = ST_ERR;
      ST_ERR:   state_d = ST_CV;
      ST_CV:    state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Operand selection for the shared units
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    cor_cmd = '0;
    cor_x   = '0;
    cor_y   = '0;
    unique case (state_q)
      ST_BX: begin
        mul_a = MW'(in_q.gps_x) - MW'(px_q);
        mul_b = MB'($signed({1'b0, ggain_q}));
      end
      ST_BY: begin
        mul_a = MW'(in_q.gps_y) - MW'(py_q);
        mul_b = MB'($signed({1'b0, ggain_q}));
      end
      ST_DL: begin
        mul_a = MW'(in_q.speed);
        mul_b = MB'($signed({1'b0, tick_q}));
      end
      ST_RT: begin
        mul_a = MW'(in_q.yaw_rate);
        mul_b = MB'($signed({1'b0, tick_q}));
      end
      ST_RAD: begin
        mul_a = prod_q[MW-1:0];
        mul_b = MB'(RAD_TO_ANG);
      end
      ST_SC_GO: cor_cmd.go = 1'b1;
      ST_DX: begin
        mul_a = MW'(dl_q);
        mul_b = MB'(cor_xo);
      end
      ST_DY: begin
        mul_a = MW'(dl_q);
        mul_b = MB'(cor_yo);
      end
      ST_AG_GO: begin
        cor_cmd = '{go: 1'b1, vect: 1'b1};
        cor_x   = CIN'(px_q) - CIN'(ax_q);
        cor_y   = CIN'(py_q) - CIN'(ay_q);
      end
      ST_AO_GO: begin
        cor_cmd = '{go: 1'b1, vect: 1'b1};
        cor_x   = CIN'(sx_q);
        cor_y   = CIN'(sy_q);
      end
      ST_ERR: begin
        mul_a = MW'(err);
        mul_b = MB'($signed({1'b0, hgain_q}));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      heading_q   <= '0;
      px_q        <= '0;
      py_q        <= '0;
      ax_q        <= '0;
      ay_q        <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      trav_q      <= '0;
    end else begin
      state_q <= state_d;
      // new pose loads as the old one leaves or the register is empty
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          if (in_q.start_req) begin
            px_q      <= sat(SW'(in_q.gps_x));
            ax_q      <= sat(SW'(in_q.gps_x));
            py_q      <= sat(SW'(in_q.gps_y));
            ay_q      <= sat(SW'(in_q.gps_y));
            sx_q      <= '0;
            sy_q      <= '0;
            trav_q    <= '0;
            heading_q <= '0;
          end
        end
        ST_BY:  px_q   <= sat(SW'(px_q) + SW'(r16));
        ST_DL:  py_q   <= sat(SW'(py_q) + SW'(r16));
        ST_RT:  trav_q <= sat(SW'(trav_q) + SW'(r12));
        ST_INC: heading_q <= heading_q + rinc[AB-1:0];
        ST_DY: begin
          px_q <= sat(SW'(px_q) + SW'(r30));
          sx_q <= sat(SW'(sx_q) + SW'(r30));
        end
        ST_DYU: begin
          py_q <= sat(SW'(py_q) + SW'(r30));
          sy_q <= sat(SW'(sy_q) + SW'(r30));
        end
        ST_CV: begin
          heading_q <= heading_q + rcv[AB-1:0];
          ax_q      <= px_q;
          ay_q      <= py_q;
          sx_q      <= '0;
          sy_q      <= '0;
          trav_q    <= '0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) in_q <= in_data_i;
        corr_q <= 1'b0;
      end
      ST_RT:    dl_q <= r12[DL_WIDTH-1:0];
      ST_AG_WT: if (cor_rsp.done) ag_q <= cor_zo;
      ST_CV:    corr_q <= 1'b1;
      ST_OUT: begin
        if (out_free) begin
          out_q.est_x     <= sat32(px_q);
          out_q.est_y     <= sat32(py_q);
          out_q.est_yaw   <= $signed(h16);
          out_q.corrected <= corr_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a tick is still in flight");

  a_cordic_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !cor_rsp.busy)
    else $error("CORDIC busy while sequencer idle");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside the output step");

endmodule
`default_nettype wire

// ===== hw/rtl/gpf_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// GPS / odometry fuser CORDIC
// One step per cycle: sin/cos by rotation, or atan2 by vectoring after a
// one-bit-per-cycle normalization of the operands.
// ----------------------------------------------------------------------------
module gpf_cordic import gpf_pkg::*; #(
  parameter int DW  = 42,
  parameter int CIN = 33
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cor_cmd_t              cmd_i,
  input  wire logic        [15:0]    ang_i,
  input  wire logic signed [CIN-1:0] xin_i,
  input  wire logic signed [CIN-1:0] yin_i,
  output      logic signed [DW-1:0]  x_o,
  output      logic signed [DW-1:0]  y_o,
  output      logic        [15:0]    z_o,
  output      cor_rsp_t              rsp_o
);

  localparam logic signed [DW-1:0] HI = DW'(1) << 39;
  localparam logic signed [DW-1:0] LO = DW'(1) << 38;

  cor_state_e state_q, state_d;
  logic signed [DW-1:0] x_q, y_q;
  logic signed [17:0]   z_q;
  logic [3:0]           it_q;
  logic                 vect_q, flip_q;

  logic signed [17:0] a18, ang_adj;
  logic               ang_flip;
  logic               is_zero, any_hi, both_lo, dir;
  logic signed [DW-1:0] sx, sy;
  logic signed [17:0] at;

  always_comb begin
    a18 = 18'($signed(ang_i));
    ang_adj  = a18;
    ang_flip = 1'b0;
    if (a18 > 18'sd16384) begin
      ang_adj  = a18 - 18'sd32768;
      ang_flip = 1'b1;
    end else if (a18 < -18'sd16384) begin
      ang_adj  = a18 + 18'sd32768;
      ang_flip = 1'b1;
    end
  end

  assign is_zero = (x_q == '0) && (y_q == '0);
  assign any_hi  = (x_q >= HI) || (x_q <= -HI) || (y_q >= HI) || (y_q <= -HI);
  assign both_lo = (x_q < LO) && (x_q > -LO) && (y_q < LO) && (y_q > -LO);
  assign sx  = x_q >>> it_q;
  assign sy  = y_q >>> it_q;
  assign at  = 18'(ATAN_TAB[it_q]);
  assign dir = vect_q ? y_q[DW-1] : !z_q[17];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      COR_IDLE: begin
        if (cmd_i.go) state_d = cmd_i.vect ? COR_NORM : COR_ITER;
      end
      COR_NORM: begin
        if (is_zero) state_d = COR_DONE;
        else if (!any_hi && !both_lo) state_d = COR_FLIP;
      end
      COR_FLIP: state_d = COR_ITER;
      COR_ITER: begin
        if (it_q == 4'(CORDIC_ITERS - 1)) state_d = COR_DONE;
      end
      COR_DONE: state_d = COR_IDLE;
      default:  state_d = COR_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.busy = (state_q != COR_IDLE);
    rsp_o.done = (state_q == COR_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= COR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      COR_IDLE: begin
        if (cmd_i.go) begin
          vect_q <= cmd_i.vect;
          it_q   <= '0;
          if (cmd_i.vect) begin
            x_q    <= DW'(xin_i);
            y_q    <= DW'(yin_i);
            z_q    <= '0;
            flip_q <= 1'b0;
          end else begin
            x_q    <= DW'(CORDIC_K);
            y_q    <= '0;
            z_q    <= ang_adj;
            flip_q <= ang_flip;
          end
        end
      end
      COR_NORM: begin
        if (is_zero) begin
          z_q <= '0;
        end else if (any_hi) begin
          x_q <= x_q >>> 1;
          y_q <= y_q >>> 1;
        end else if (both_lo) begin
          x_q <= x_q <<< 1;
          y_q <= y_q <<< 1;
        end
      end
      COR_FLIP: begin
        if (x_q[DW-1]) begin
          x_q <= -x_q;
          y_q <= -y_q;
          z_q <= 18'sd32768;
        end
      end
      COR_ITER: begin
        if (dir) begin
          x_q <= x_q - sy;
          y_q <= y_q + sx;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + sy;
          y_q <= y_q - sx;
          z_q <= z_q + at;
        end
        it_q <= it_q + 4'd1;
      end
      COR_DONE: ;
      default: ;
    endcase
  end

  // Sin/cos results fold back across the half-plane when the angle was flipped
  assign x_o = (!vect_q && flip_q) ? -x_q : x_q;
  assign y_o = (!vect_q && flip_q) ? -y_q : y_q;
  assign z_o = z_q[15:0];

endmodule
`default_nettype wire
